/* hw/rtl/md5_pkg.sv */
// Package with the MD5 sequencer states, initial chaining values and round tables.
package md5_pkg;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PAD,
    ST_ROUND,
    ST_ADD,
    ST_OUT
  } md5_state_e;

  typedef logic [31:0] word_t;

  localparam word_t CHAIN_INIT [4] = '{
    32'h67452301, 32'hefcdab89, 32'h98badcfe, 32'h10325476
  };

  localparam logic [7:0] PAD_FIRST_BYTE = 8'h80;
  localparam logic [5:0] LEN_POSITION   = 6'd56;
  localparam logic [5:0] LAST_POSITION  = 6'd63;
  localparam logic [5:0] LAST_ROUND     = 6'd63;

  // The shift amount repeats every four rounds within each group of sixteen.
  function automatic logic [4:0] shift_amt(input logic [1:0] grp, input logic [1:0] sel);
    logic [4:0] s;
    s = 5'd7;
    case (grp)
      2'd0: begin
        case (sel)
          2'd0: s = 5'd7;
          2'd1: s = 5'd12;
          2'd2: s = 5'd17;
          default: s = 5'd22;
        endcase
      end
      2'd1: begin
        case (sel)
          2'd0: s = 5'd5;
          2'd1: s = 5'd9;
          2'd2: s = 5'd14;
          default: s = 5'd20;
        endcase
      end
      2'd2: begin
        case (sel)
          2'd0: s = 5'd4;
          2'd1: s = 5'd11;
          2'd2: s = 5'd16;
          default: s = 5'd23;
        endcase
      end
      default: begin
        case (sel)
          2'd0: s = 5'd6;
          2'd1: s = 5'd10;
          2'd2: s = 5'd15;
          default: s = 5'd21;
        endcase
      end
    endcase
    return s;
  endfunction

  localparam word_t SINE_K [64] = '{
    32'hd76aa478, 32'he8c7b756, 32'h242070db, 32'hc1bdceee,
    32'hf57c0faf, 32'h4787c62a, 32'ha8304613, 32'hfd469501,
    32'h698098d8, 32'h8b44f7af, 32'hffff5bb1, 32'h895cd7be,
    32'h6b901122, 32'hfd987193, 32'ha679438e, 32'h49b40821,
    32'hf61e2562, 32'hc040b340, 32'h265e5a51, 32'he9b6c7aa,
    32'hd62f105d, 32'h02441453, 32'hd8a1e681, 32'he7d3fbc8,
    32'h21e1cde6, 32'hc33707d6, 32'hf4d50d87, 32'h455a14ed,
    32'ha9e3e905, 32'hfcefa3f8, 32'h676f02d9, 32'h8d2a4c8a,
    32'hfffa3942, 32'h8771f681, 32'h6d9d6122, 32'hfde5380c,
    32'ha4beea44, 32'h4bdecfa9, 32'hf6bb4b60, 32'hbebfbc70,
    32'h289b7ec6, 32'heaa127fa, 32'hd4ef3085, 32'h04881d05,
    32'hd9d4d039, 32'he6db99e5, 32'h1fa27cf8, 32'hc4ac5665,
    32'hf4292244, 32'h432aff97, 32'hab9423a7, 32'hfc93a039,
    32'h655b59c3, 32'h8f0ccc92, 32'hffeff47d, 32'h85845dd1,
    32'h6fa87e4f, 32'hfe2ce6e0, 32'ha3014314, 32'h4e0811a1,
    32'hf7537e82, 32'hbd3af235, 32'h2ad7d2bb, 32'heb86d391
  };

endpackage

/* hw/rtl/md5_hash.sv */
// Streaming MD5 engine: byte packing, padding, one shared round unit and digest output.
//
//  Channel  | Dir | tdata               | tuser           | tlast
//  s_axis   | in  | data_byte [7:0]     | has_byte        | end_of_message
//  m_axis   | out | digest_word [31:0]  | word_index[1:0] | last_word
//
// A byte that does not fill the block is taken while the engine is idle, so such bytes
// can follow back to back. The byte that fills the block is followed by the single round
// unit, one MD5 round per cycle for all 64 rounds, then a step that adds into the
// chaining words; the input is not ready meanwhile.
// End of message adds the padding bytes (up to 64), the length, one or two block
// compressions, and four output words; the input is not ready meanwhile.
// Reset loads the MD5 initial chaining words and clears length and position.
// A stalled output holds the current digest word until it is taken.
module md5_hash
  import md5_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [7:0]  s_axis_tdata_i,   // [7:0] data_byte
  input  logic        s_axis_tuser_i,   // [0] has_byte
  input  logic        s_axis_tlast_i,   // end_of_message
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [31:0] m_axis_tdata_o,   // [31:0] digest_word
  output logic [1:0]  m_axis_tuser_o,   // [1:0] word_index
  output logic        m_axis_tlast_o    // last_word
);

  md5_state_e state_q, state_d;

  word_t       block_q [16];
  word_t       chain_q [4];
  word_t       a_q, b_q, c_q, d_q;
  logic [5:0]  pos_q;
  logic [63:0] bits_q;
  logic [5:0]  rc_q;
  logic [1:0]  idx_q;
  logic        need80_q;
  logic        pend_q;
  logic        final_q;

  logic        in_acc;
  logic        out_acc;
  logic        len_write;
  logic        wr_en;
  logic [7:0]  wr_byte;

  logic [3:0]  i4;
  logic [3:0]  g;
  word_t       f;
  word_t       x;
  word_t       rot;
  logic [63:0] rot_wide;
  logic [4:0]  sh;

  assign in_acc  = s_axis_tvalid_i && s_axis_tready_o;
  assign out_acc = m_axis_tvalid_o && m_axis_tready_i;

  // In the padding state the length goes in once the 0x80 byte is out and
  // the position sits at byte 56.
  assign len_write = (state_q == ST_PAD) && !need80_q && (pos_q == LEN_POSITION);

  always_comb begin
    wr_en   = 1'b0;
    wr_byte = s_axis_tdata_i;
    if (state_q == ST_IDLE) begin
      wr_en = in_acc && s_axis_tuser_i;
    end else if (state_q == ST_PAD && !len_write) begin
      wr_en   = 1'b1;
      wr_byte = need80_q ? PAD_FIRST_BYTE : 8'h00;
    end
  end

  // Round unit.
  assign i4 = rc_q[3:0];
  always_comb begin
    case (rc_q[5:4])
      2'd0: begin
        f = (b_q & c_q) | (~b_q & d_q);
        g = i4;
      end
      2'd1: begin
        f = (d_q & b_q) | (~d_q & c_q);
        g = (i4 * 4'd5) + 4'd1;
      end
      2'd2: begin
        f = b_q ^ c_q ^ d_q;
        g = (i4 * 4'd3) + 4'd5;
      end
      default: begin
        f = c_q ^ (b_q | ~d_q);
        g = i4 * 4'd7;
      end
    endcase
  end

  assign sh       = shift_amt(rc_q[5:4], rc_q[1:0]);
  assign x        = a_q + f + SINE_K[rc_q] + block_q[g];
  assign rot_wide = {x, x} << sh;
  assign rot      = rot_wide[63:32];

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          if (s_axis_tuser_i && pos_q == LAST_POSITION) begin
            state_d = ST_ROUND;
          end else if (s_axis_tlast_i) begin
            state_d = ST_PAD;
          end
        end
      end
      ST_PAD: begin
        if (len_write || pos_q == LAST_POSITION) begin
          state_d = ST_ROUND;
        end
      end
      ST_ROUND: begin
        if (rc_q == LAST_ROUND) begin
          state_d = ST_ADD;
        end
      end
      ST_ADD: begin
        if (final_q) begin
          state_d = ST_OUT;
        end else if (pend_q) begin
          state_d = ST_PAD;
        end else begin
          state_d = ST_IDLE;
        end
      end
      ST_OUT: begin
        if (out_acc && idx_q == 2'd3) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Handshake outputs.
  always_comb begin
    s_axis_tready_o = 1'b0;
    m_axis_tvalid_o = 1'b0;
    case (state_q)
      ST_IDLE: s_axis_tready_o = 1'b1;
      ST_OUT:  m_axis_tvalid_o = 1'b1;
      default: begin
        s_axis_tready_o = 1'b0;
        m_axis_tvalid_o = 1'b0;
      end
    endcase
  end

  assign m_axis_tdata_o = chain_q[idx_q];
  assign m_axis_tuser_o = idx_q;
  assign m_axis_tlast_o = (idx_q == 2'd3);

  // Message block, written a byte lane at a time; the length fills words 14 and 15 at once.
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      block_q[pos_q[5:2]][{pos_q[1:0], 3'b000} +: 8] <= wr_byte;
    end
    if (len_write) begin
      block_q[14] <= bits_q[31:0];
      block_q[15] <= bits_q[63:32];
    end
  end

  // Working words of the round unit.
  always_ff @(posedge clk_i) begin
    if (state_q != ST_ROUND && state_d == ST_ROUND) begin
      a_q <= chain_q[0];
      b_q <= chain_q[1];
      c_q <= chain_q[2];
      d_q <= chain_q[3];
    end else if (state_q == ST_ROUND) begin
      a_q <= d_q;
      d_q <= c_q;
      c_q <= b_q;
      b_q <= b_q + rot;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      chain_q  <= CHAIN_INIT;
      pos_q    <= '0;
      bits_q   <= '0;
      rc_q     <= '0;
      idx_q    <= '0;
      need80_q <= 1'b0;
      pend_q   <= 1'b0;
      final_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      if (wr_en) begin
        pos_q <= pos_q + 6'd1;
      end
      case (state_q)
        ST_IDLE: begin
          if (in_acc) begin
            pend_q   <= s_axis_tlast_i;
            need80_q <= 1'b1;
            final_q  <= 1'b0;
            if (s_axis_tuser_i) begin
              bits_q <= bits_q + 64'd8;
            end
          end
        end
        ST_PAD: begin
          if (len_write) begin
            final_q <= 1'b1;
            pos_q   <= '0;
          end else begin
            need80_q <= 1'b0;
          end
        end
        ST_ROUND: begin
          rc_q <= rc_q + 6'd1;
        end
        ST_ADD: begin
          chain_q[0] <= chain_q[0] + a_q;
          chain_q[1] <= chain_q[1] + b_q;
          chain_q[2] <= chain_q[2] + c_q;
          chain_q[3] <= chain_q[3] + d_q;
          idx_q      <= '0;
        end
        ST_OUT: begin
          if (out_acc) begin
            idx_q <= idx_q + 2'd1;
            if (idx_q == 2'd3) begin
              chain_q <= CHAIN_INIT;
              bits_q  <= '0;
              pos_q   <= '0;
              pend_q  <= 1'b0;
              final_q <= 1'b0;
            end
          end
        end
        default: begin
          rc_q <= rc_q;
        end
      endcase
    end
  end

endmodule
